### sv/breath_note_detector_core_assert.svh
// Assertion macros of the breath note detector, included by bnd_step.
// Depends on nothing; included inside module bodies after the logic.
`ifndef BREATH_NOTE_DETECTOR_CORE_ASSERT_SVH
`define BREATH_NOTE_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define BND_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bnd_pkg.sv
// Shared types and constants for the breath note detector.
// Depends on nothing; used by every module of the block.
package bnd_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF  = 8;

    localparam int BAND_W  = 10;
    localparam int REQ_W   = 8;
    localparam int INIT_W  = 12;
    localparam int NOTE_W  = 7;
    localparam int VOICE_W = 2;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = ADDR_W - 2;

    typedef logic [IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_BAND_OFFSET    = 3'd0;
    localparam t_reg_idx REG_REQUIRED_COUNT = 3'd1;
    localparam t_reg_idx REG_BASELINE_INIT  = 3'd2;
    localparam t_reg_idx REG_BLOW_NOTE      = 3'd3;
    localparam t_reg_idx REG_DRAW_NOTE      = 3'd4;
    localparam t_reg_idx REG_VOICE_SELECT   = 3'd5;

    localparam logic [BAND_W-1:0]  RST_BAND_OFFSET    = 10'd20;
    localparam logic [REQ_W-1:0]   RST_REQUIRED_COUNT = 8'd5;
    localparam logic [INIT_W-1:0]  RST_BASELINE_INIT  = 12'd0;
    localparam logic [NOTE_W-1:0]  RST_BLOW_NOTE      = 7'd60;
    localparam logic [NOTE_W-1:0]  RST_DRAW_NOTE      = 7'd62;
    localparam logic [VOICE_W-1:0] RST_VOICE_SELECT   = 2'd1;

    localparam logic EV_NOTE_ON  = 1'b0;
    localparam logic EV_NOTE_OFF = 1'b1;

    typedef struct packed {
        logic [BAND_W-1:0]  band_offset;
        logic [REQ_W-1:0]   required_count;
        logic [NOTE_W-1:0]  blow_note;
        logic [NOTE_W-1:0]  draw_note;
        logic [VOICE_W-1:0] voice_select;
        logic               baseline_load;
        logic [INIT_W-1:0]  baseline_value;
    } t_cfg;

endpackage

### sv/bnd_regs.sv
// Configuration register file of the breath note detector, APB-style port.
// Depends on bnd_pkg; drives the t_cfg bundle consumed by bnd_step.
module bnd_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bnd_pkg::ADDR_W-1:0] paddr,
    input  logic [bnd_pkg::DATA_W-1:0] pwdata,
    output logic [bnd_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output bnd_pkg::t_cfg             o_cfg
);
    import bnd_pkg::*;

    logic [BAND_W-1:0]  r_band_offset;
    logic [REQ_W-1:0]   r_required_count;
    logic [INIT_W-1:0]  r_baseline_init;
    logic [NOTE_W-1:0]  r_blow_note;
    logic [NOTE_W-1:0]  r_draw_note;
    logic [VOICE_W-1:0] r_voice_select;

    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_offset    <= RST_BAND_OFFSET;
            r_required_count <= RST_REQUIRED_COUNT;
            r_baseline_init  <= RST_BASELINE_INIT;
            r_blow_note      <= RST_BLOW_NOTE;
            r_draw_note      <= RST_DRAW_NOTE;
            r_voice_select   <= RST_VOICE_SELECT;
        end else if (wr_en) begin
            case (idx)
                REG_BAND_OFFSET:    r_band_offset    <= pwdata[BAND_W-1:0];
                REG_REQUIRED_COUNT: r_required_count <= pwdata[REQ_W-1:0];
                REG_BASELINE_INIT:  r_baseline_init  <= pwdata[INIT_W-1:0];
                REG_BLOW_NOTE:      r_blow_note      <= pwdata[NOTE_W-1:0];
                REG_DRAW_NOTE:      r_draw_note      <= pwdata[NOTE_W-1:0];
                REG_VOICE_SELECT:   r_voice_select   <= pwdata[VOICE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_BAND_OFFSET:    prdata = DATA_W'(r_band_offset);
            REG_REQUIRED_COUNT: prdata = DATA_W'(r_required_count);
            REG_BASELINE_INIT:  prdata = DATA_W'(r_baseline_init);
            REG_BLOW_NOTE:      prdata = DATA_W'(r_blow_note);
            REG_DRAW_NOTE:      prdata = DATA_W'(r_draw_note);
            REG_VOICE_SELECT:   prdata = DATA_W'(r_voice_select);
            default:            prdata = '0;
        endcase
    end

    // The baseline state loads at the same edge that writes the register.
    always_comb begin
        o_cfg.band_offset    = r_band_offset;
        o_cfg.required_count = r_required_count;
        o_cfg.blow_note      = r_blow_note;
        o_cfg.draw_note      = r_draw_note;
        o_cfg.voice_select   = r_voice_select;
        o_cfg.baseline_load  = wr_en && (idx == REG_BASELINE_INIT);
        o_cfg.baseline_value = pwdata[INIT_W-1:0];
    end

endmodule

### sv/bnd_ema.sv
// Baseline tracker: next baseline = floor((sample + 9*baseline) / 10).
// Depends on bnd_pkg for the default width; used by bnd_step.
module bnd_ema #(
    parameter int SAMPLE_BITS = bnd_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_baseline,
    output logic [SAMPLE_BITS-1:0] o_baseline
);
    localparam int SUM_W       = SAMPLE_BITS + 4;
    localparam int RECIP_SHIFT = SUM_W + 4;
    localparam longint RECIP_VAL = (longint'(1) << RECIP_SHIFT) / 10 + 1;
    localparam int RECIP_W     = RECIP_SHIFT - 2;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;

    // Divide by ten through a reciprocal; the extra shift bits keep the
    // truncated quotient exact over the whole sum range.
    assign sum        = (SUM_W'(i_baseline) << 3) + SUM_W'(i_baseline) + SUM_W'(i_sample);
    assign prod       = PROD_W'(sum) * PROD_W'(RECIP);
    assign o_baseline = SAMPLE_BITS'(prod >> RECIP_SHIFT);

endmodule

### sv/bnd_step.sv
// Sample input register, detector state and event output register.
// Depends on bnd_pkg, bnd_ema and the assertion macro header.
module bnd_step #(
    parameter int SAMPLE_BITS = bnd_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = bnd_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bnd_pkg::t_cfg                i_cfg,
    input  logic                         i_sample_valid,
    output logic                         o_sample_ready,
    input  logic [SAMPLE_BITS-1:0]       i_sample,
    output logic                         o_event_valid,
    input  logic                         i_event_ready,
    output logic                         o_event_kind,
    output logic [bnd_pkg::NOTE_W-1:0]   o_note_number,
    output logic [bnd_pkg::VOICE_W-1:0]  o_voice
);
    import bnd_pkg::*;

    localparam int CMP_W = ((SAMPLE_BITS > BAND_W) ? SAMPLE_BITS : BAND_W) + 1;
    localparam int RUN_W = (COUNT_BITS > REQ_W) ? COUNT_BITS : REQ_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_sample;

    logic [SAMPLE_BITS-1:0] r_baseline;
    logic [COUNT_BITS-1:0]  r_high_run;
    logic [COUNT_BITS-1:0]  r_low_run;
    logic                   r_sounding;
    logic [NOTE_W-1:0]      r_sounding_note;

    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [NOTE_W-1:0]      r_out_note;
    logic [VOICE_W-1:0]     r_out_voice;

    logic [SAMPLE_BITS-1:0] n_baseline;
    logic [COUNT_BITS-1:0]  n_high_run;
    logic [COUNT_BITS-1:0]  n_low_run;
    logic                   n_sounding;
    logic [NOTE_W-1:0]      n_sounding_note;
    logic                   n_emit;
    logic                   n_kind;
    logic [NOTE_W-1:0]      n_note;

    logic                   out_free;
    logic                   advance;
    logic [CMP_W-1:0]       s_ext;
    logic [CMP_W-1:0]       b_ext;
    logic [CMP_W-1:0]       off_ext;
    logic                   is_high;
    logic                   is_low;
    logic                   is_quiet;
    logic [RUN_W-1:0]       req_ext;
    logic [COUNT_BITS-1:0]  high_inc;
    logic [COUNT_BITS-1:0]  low_inc;
    logic [SAMPLE_BITS-1:0] ema_baseline;

    // A held sample moves on whenever the output register is empty or drained.
    assign out_free       = !r_out_valid || i_event_ready;
    assign advance        = r_in_valid && out_free;
    assign o_sample_ready = !r_in_valid || out_free;

    assign s_ext   = CMP_W'(r_in_sample);
    assign b_ext   = CMP_W'(r_baseline);
    assign off_ext = CMP_W'(i_cfg.band_offset);

    // High takes priority over low and quiet; low is compared as s + off <= b.
    assign is_high  = !r_sounding && (s_ext >= b_ext + off_ext);
    assign is_low   = !r_sounding && !is_high && (s_ext + off_ext <= b_ext);
    assign is_quiet = !is_high && !is_low && (s_ext + off_ext >= b_ext)
                      && (s_ext <= b_ext + off_ext);

    assign req_ext  = RUN_W'(i_cfg.required_count);
    assign high_inc = ((RUN_W'(r_high_run) < req_ext) && (r_high_run != COUNT_MAX))
                      ? r_high_run + 1'b1 : r_high_run;
    assign low_inc  = ((RUN_W'(r_low_run) < req_ext) && (r_low_run != COUNT_MAX))
                      ? r_low_run + 1'b1 : r_low_run;

    bnd_ema #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_ema (
        .i_sample   (r_in_sample),
        .i_baseline (r_baseline),
        .o_baseline (ema_baseline)
    );

    always_comb begin
        n_baseline      = r_baseline;
        n_high_run      = r_high_run;
        n_low_run       = r_low_run;
        n_sounding      = r_sounding;
        n_sounding_note = r_sounding_note;
        n_emit          = 1'b0;
        n_kind          = EV_NOTE_ON;
        n_note          = r_sounding_note;
        if (is_high) begin
            n_high_run = high_inc;
            n_low_run  = '0;
            if (RUN_W'(high_inc) >= req_ext) begin
                n_sounding      = 1'b1;
                n_sounding_note = i_cfg.blow_note;
                n_emit          = 1'b1;
                n_note          = i_cfg.blow_note;
            end
        end else if (is_low) begin
            n_low_run  = low_inc;
            n_high_run = '0;
            if (RUN_W'(low_inc) >= req_ext) begin
                n_sounding      = 1'b1;
                n_sounding_note = i_cfg.draw_note;
                n_emit          = 1'b1;
                n_note          = i_cfg.draw_note;
            end
        end else if (is_quiet) begin
            n_baseline = ema_baseline;
            n_high_run = '0;
            n_low_run  = '0;
            if (r_sounding) begin
                n_emit          = 1'b1;
                n_kind          = EV_NOTE_OFF;
                n_sounding      = 1'b0;
                n_sounding_note = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_sample_ready) begin
            r_in_valid <= i_sample_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_sample_ready && i_sample_valid) begin
            r_in_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline      <= SAMPLE_BITS'(RST_BASELINE_INIT);
            r_high_run      <= '0;
            r_low_run       <= '0;
            r_sounding      <= 1'b0;
            r_sounding_note <= '0;
        end else if (i_cfg.baseline_load) begin
            r_baseline <= SAMPLE_BITS'(i_cfg.baseline_value);
        end else if (advance) begin
            r_baseline      <= n_baseline;
            r_high_run      <= n_high_run;
            r_low_run       <= n_low_run;
            r_sounding      <= n_sounding;
            r_sounding_note <= n_sounding_note;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_emit) begin
            r_out_kind  <= n_kind;
            r_out_note  <= n_note;
            r_out_voice <= i_cfg.voice_select;
        end
    end

    assign o_event_valid = r_out_valid;
    assign o_event_kind  = r_out_kind;
    assign o_note_number = r_out_note;
    assign o_voice       = r_out_voice;

`include "breath_note_detector_core_assert.svh"

    `BND_ASSERT_NOW(a_runs_exclusive, i_clk, i_rst_n, 1'b1, (r_high_run == '0) || (r_low_run == '0), "both run counters are nonzero")
    `BND_ASSERT_NOW(a_idle_note_clear, i_clk, i_rst_n, !r_sounding, r_sounding_note == '0, "note held while silent")
    `BND_ASSERT_NEXT(a_quiet_clears, i_clk, i_rst_n, advance && is_quiet, (r_high_run == '0) && (r_low_run == '0), "quiet sample left a run count")
    `BND_ASSERT_NEXT(a_event_lands, i_clk, i_rst_n, advance && n_emit, r_out_valid, "event lost at the output register")
    `BND_ASSERT_NEXT(a_note_on_sounds, i_clk, i_rst_n, advance && n_emit && (n_kind == EV_NOTE_ON), r_sounding, "note-on without a sounding note")

endmodule

### sv/breath_note_detector_core.sv
// Top level of the breath note detector: register file plus detector step.
// Depends on bnd_pkg, bnd_regs, bnd_step and bnd_ema.
//
//  channel  | direction | handshake                          | payload
//  ---------+-----------+------------------------------------+--------------------------
//  sample   | in        | i_sample_valid / o_sample_ready    | i_sample
//  event    | out       | o_event_valid / i_event_ready      | o_event_kind, o_note_number, o_voice
//  config   | in        | psel, penable, pwrite / pready     | paddr, pwdata, prdata
//
// One sample is taken per cycle unless a held sample waits on a full output register;
// a transfer is classified once it is held and the output register is free, and any
// event it raises is valid on the event channel from the end of that cycle.
// The compare, run counters and divide-by-ten baseline update sit between the
// sample register and the event register.
// While an event waits, the block still takes one more sample; the next one
// waits until the event transfer frees the output register.
// Synchronous active-low reset restores the register defaults and clears state.
module breath_note_detector_core #(
    parameter int SAMPLE_BITS = bnd_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = bnd_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bnd_pkg::ADDR_W-1:0]   paddr,
    input  logic [bnd_pkg::DATA_W-1:0]   pwdata,
    output logic [bnd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         i_sample_valid,
    output logic                         o_sample_ready,
    input  logic [SAMPLE_BITS-1:0]       i_sample,
    output logic                         o_event_valid,
    input  logic                         i_event_ready,
    output logic                         o_event_kind,
    output logic [bnd_pkg::NOTE_W-1:0]   o_note_number,
    output logic [bnd_pkg::VOICE_W-1:0]  o_voice
);
    import bnd_pkg::*;

    t_cfg cfg;

    bnd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bnd_step #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_event_valid  (o_event_valid),
        .i_event_ready  (i_event_ready),
        .o_event_kind   (o_event_kind),
        .o_note_number  (o_note_number),
        .o_voice        (o_voice)
    );

endmodule
